// ===== hdl/mrs_pkg.sv =====
package mrs_pkg;

    localparam int ELEM_W    = 32;
    localparam int SUM_W     = 35;
    localparam int SIZE_W    = 4;
    localparam int OUT_IDX_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // descriptor of one loaded matrix waiting for the back end
    typedef struct packed {
        logic [SIZE_W-1:0] dim;
        logic              bank;
    } t_job_ctl;

    // magnitude of a two's complement element, -2^31 gives 2^31
    function automatic logic [ELEM_W-1:0] abs_elem(input logic [ELEM_W-1:0] v);
        abs_elem = v[ELEM_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== hdl/mrs_front.sv =====
module mrs_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [mrs_pkg::SIZE_W-1:0]              i_size,
    input  logic                                    i_clear,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [mrs_pkg::ELEM_W-1:0]       i_element_value,
    input  logic                                    i_full,
    output logic                                    o_mem_we,
    output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] o_mem_addr,
    output logic [mrs_pkg::ELEM_W-1:0]              o_mem_data,
    output logic                                    o_push,
    output mrs_pkg::t_job_ctl                       o_job,
    output logic [MAX_DIM-1:0][mrs_pkg::SUM_W-1:0]  o_sums
);
    import mrs_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [SIZE_W-1:0]                dim;
    logic [IW-1:0]                    r_row;
    logic [IW-1:0]                    r_col;
    logic                             r_bank;
    logic [SUM_W-1:0]                 r_acc;
    logic [SUM_W-1:0]                 n_acc;
    logic [MAX_DIM-1:0][SUM_W-1:0]    r_sums;
    logic                             accept;
    logic                             col_last;
    logic                             row_last;

    // clamp the size register to 1..MAX_DIM
    always_comb begin
        if (i_size == '0) begin
            dim = SIZE_W'(1);
        end else if (i_size > SIZE_W'(MAX_DIM)) begin
            dim = SIZE_W'(MAX_DIM);
        end else begin
            dim = i_size;
        end
    end

    assign accept   = i_valid && !i_full;
    assign o_stall  = i_full;
    assign col_last = (SIZE_W'(r_col) == dim - 1'b1);
    assign row_last = (SIZE_W'(r_row) == dim - 1'b1);
    assign n_acc    = r_acc + SUM_W'(abs_elem(i_element_value));

    assign o_mem_we   = accept;
    assign o_mem_addr = {r_bank, r_row, r_col};
    assign o_mem_data = i_element_value;
    assign o_push     = accept && col_last && row_last;
    assign o_job.dim  = dim;
    assign o_job.bank = r_bank;

    always_comb begin
        o_sums        = r_sums;
        o_sums[r_row] = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bank <= 1'b0;
            r_acc  <= '0;
        end else if (i_clear) begin
            r_row <= '0;
            r_col <= '0;
            r_acc <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_acc <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_bank <= ~r_bank;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
                r_acc <= n_acc;
            end
        end
    end

    // finished row sums
    always_ff @(posedge i_clk) begin
        if (accept && col_last) begin
            r_sums[r_row] <= n_acc;
        end
    end

endmodule

// ===== hdl/mrs_jobq.sv =====
module mrs_jobq #(
    parameter int MAX_DIM = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    input  mrs_pkg::t_job_ctl                       i_job,
    input  logic [MAX_DIM-1:0][mrs_pkg::SUM_W-1:0]  i_sums,
    input  logic                                    i_pop,
    output logic                                    o_valid,
    output logic                                    o_full,
    output mrs_pkg::t_job_ctl                       o_job,
    output logic [MAX_DIM-1:0][mrs_pkg::SUM_W-1:0]  o_sums
);
    import mrs_pkg::*;

    // two entries, one per memory bank
    t_job_ctl                         r_job  [2];
    logic [MAX_DIM-1:0][SUM_W-1:0]    r_sums [2];
    logic                             r_wr_ptr;
    logic                             r_rd_ptr;
    logic [1:0]                       r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_job[r_rd_ptr];
    assign o_sums  = r_sums[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wr_ptr]  <= i_job;
            r_sums[r_wr_ptr] <= i_sums;
        end
    end

endmodule

// ===== hdl/mrs_back.sv =====
module mrs_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_mem_we,
    input  logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1):0] i_mem_addr,
    input  logic [mrs_pkg::ELEM_W-1:0]              i_mem_data,
    input  logic                                    i_job_valid,
    input  mrs_pkg::t_job_ctl                       i_job,
    input  logic [MAX_DIM-1:0][mrs_pkg::SUM_W-1:0]  i_sums,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [mrs_pkg::ELEM_W-1:0]       o_out_value,
    output logic [mrs_pkg::OUT_IDX_W-1:0]           o_out_row,
    output logic [mrs_pkg::OUT_IDX_W-1:0]           o_out_col,
    output logic                                    o_last_of_matrix
);
    import mrs_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * IW + 1;
    localparam int DEPTH = 2 ** AW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SORT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [ELEM_W-1:0]              mem [DEPTH];

    logic [1:0]                     r_state;
    logic [SIZE_W-1:0]              r_dim;
    logic                           r_bank;
    logic [IW-1:0]                  r_i;
    logic [IW-1:0]                  r_j;
    logic [IW-1:0]                  r_row;
    logic [IW-1:0]                  r_col;
    logic                           r_ov;
    logic [MAX_DIM-1:0][SUM_W-1:0]  r_sum;
    logic [MAX_DIM-1:0][IW-1:0]     r_ord;
    logic [SUM_W-1:0]               r_cur_sum;
    logic [IW-1:0]                  r_cur_ord;
    logic [ELEM_W-1:0]              r_rd;
    logic [IW-1:0]                  r_orow;
    logic [IW-1:0]                  r_ocol;
    logic                           r_olast;

    logic [IW-1:0]                  rd_idx;
    logic [SUM_W-1:0]               rd_sum;
    logic [IW-1:0]                  rd_ord;
    logic                           swap;
    logic [SUM_W-1:0]               n_cur_sum;
    logic [IW-1:0]                  n_cur_ord;
    logic                           j_last;
    logic                           i_last;
    logic                           col_last;
    logic                           row_last;
    logic                           issue;
    logic [AW-1:0]                  rd_addr;

    assign rd_idx    = (r_state == ST_LOAD) ? r_i : r_j;
    assign rd_sum    = r_sum[rd_idx];
    assign rd_ord    = r_ord[rd_idx];
    assign swap      = (r_cur_sum > rd_sum);
    assign n_cur_sum = swap ? rd_sum : r_cur_sum;
    assign n_cur_ord = swap ? rd_ord : r_cur_ord;
    assign j_last    = (SIZE_W'(r_j) == r_dim - 1'b1);
    assign i_last    = (SIZE_W'(r_i) == r_dim - 2'd2);
    assign col_last  = (SIZE_W'(r_col) == r_dim - 1'b1);
    assign row_last  = (SIZE_W'(r_row) == r_dim - 1'b1);
    assign issue     = (r_state == ST_EMIT) && (!r_ov || !i_stall);
    assign o_pop     = issue && col_last && row_last;
    assign rd_addr   = {r_bank, r_ord[r_row], r_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dim   <= '0;
            r_bank  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_dim   <= i_job.dim;
                        r_bank  <= i_job.bank;
                        r_i     <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= (i_job.dim == SIZE_W'(1)) ? ST_EMIT : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_j     <= r_i + 1'b1;
                    r_state <= ST_SORT;
                end
                ST_SORT: begin
                    if (j_last) begin
                        if (i_last) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_LOAD;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (issue) begin
                        if (col_last) begin
                            r_col <= '0;
                            if (row_last) begin
                                r_row   <= '0;
                                r_state <= ST_IDLE;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (issue) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // sort working set: position i lives in r_cur while later positions are scanned
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_sum <= i_sums;
                    for (int k = 0; k < MAX_DIM; k++) begin
                        r_ord[k] <= IW'(k);
                    end
                end
            end
            ST_LOAD: begin
                r_cur_sum <= rd_sum;
                r_cur_ord <= rd_ord;
            end
            ST_SORT: begin
                r_cur_sum <= n_cur_sum;
                r_cur_ord <= n_cur_ord;
                if (swap) begin
                    r_sum[r_j] <= r_cur_sum;
                    r_ord[r_j] <= r_cur_ord;
                end
                if (j_last) begin
                    r_sum[r_i] <= n_cur_sum;
                    r_ord[r_i] <= n_cur_ord;
                end
            end
            default: begin
            end
        endcase
    end

    // element memory, two banks, read data doubles as the output register
    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            mem[i_mem_addr] <= i_mem_data;
        end
        if (issue) begin
            r_rd    <= mem[rd_addr];
            r_orow  <= r_row;
            r_ocol  <= r_col;
            r_olast <= col_last && row_last;
        end
    end

    assign o_valid          = r_ov;
    assign o_out_value      = r_rd;
    assign o_out_row        = OUT_IDX_W'(r_orow);
    assign o_out_col        = OUT_IDX_W'(r_ocol);
    assign o_last_of_matrix = r_olast;

endmodule

// ===== hdl/matrix_row_sort_by_abs_sum.sv =====
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+----------------------------------------------
// element   | in        | i_valid / o_stall  | i_element_value
// result    | out       | o_valid / i_stall  | o_out_value, o_out_row, o_out_col,
//           |           |                    | o_last_of_matrix
// config    | in        | i_wr_en            | i_wr_data (matrix_size)
//
// elements load at one per cycle; the front stalls only while both memory banks hold
// matrices not yet fully emitted
// after the last element of an n x n matrix the back end orders the rows by an exchange sort,
// then emits the n*n elements one per cycle unless the result side stalls;
// reset is synchronous and active low, no memory clearing
// a stall on the result side holds the output register; the front keeps loading meanwhile
module matrix_row_sort_by_abs_sum #(
    parameter int MAX_DIM = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [mrs_pkg::SIZE_W-1:0]         i_wr_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [mrs_pkg::ELEM_W-1:0]  i_element_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [mrs_pkg::ELEM_W-1:0]  o_out_value,
    output logic [mrs_pkg::OUT_IDX_W-1:0]      o_out_row,
    output logic [mrs_pkg::OUT_IDX_W-1:0]      o_out_col,
    output logic                               o_last_of_matrix
);
    import mrs_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = 2 * IW + 1;

    logic [SIZE_W-1:0]              r_size;

    // front to memory write port
    logic                           mem_we;
    logic [AW-1:0]                  mem_addr;
    logic [ELEM_W-1:0]              mem_data;

    // front to job queue
    logic                           push;
    t_job_ctl                       push_job;
    logic [MAX_DIM-1:0][SUM_W-1:0]  push_sums;
    logic                           q_full;

    // job queue to back end
    logic                           q_valid;
    t_job_ctl                       head_job;
    logic [MAX_DIM-1:0][SUM_W-1:0]  head_sums;
    logic                           pop;

    // size register, a write also drops a partial load in the front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_wr_en) begin
            r_size <= i_wr_data;
        end
    end

    // front: loads elements into the free bank and accumulates absolute row sums
    mrs_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_size          (r_size),
        .i_clear         (i_wr_en),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element_value (i_element_value),
        .i_full          (q_full),
        .o_mem_we        (mem_we),
        .o_mem_addr      (mem_addr),
        .o_mem_data      (mem_data),
        .o_push          (push),
        .o_job           (push_job),
        .o_sums          (push_sums)
    );

    // two-entry queue of loaded matrices, one per bank
    mrs_jobq #(
        .MAX_DIM(MAX_DIM)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_sums  (push_sums),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (head_job),
        .o_sums  (head_sums)
    );

    // back: sorts row sums and emits the reordered matrix from the memory
    mrs_back #(
        .MAX_DIM(MAX_DIM)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mem_we         (mem_we),
        .i_mem_addr       (mem_addr),
        .i_mem_data       (mem_data),
        .i_job_valid      (q_valid),
        .i_job            (head_job),
        .i_sums           (head_sums),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_value      (o_out_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_last_of_matrix (o_last_of_matrix)
    );

endmodule

// ===== hdl/mrs_check.sv =====
module mrs_check (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [mrs_pkg::ELEM_W-1:0]  o_out_value,
    input logic [mrs_pkg::OUT_IDX_W-1:0]      o_out_row,
    input logic [mrs_pkg::OUT_IDX_W-1:0]      o_out_col,
    input logic                               o_last_of_matrix
);

    // a stalled result keeps its value
    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value))
        else $error("result value changed under stall");

    // a stalled result keeps its position and end mark
    a_hold_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_row) && $stable(o_out_col)
                               && $stable(o_last_of_matrix))
        else $error("result position changed under stall");

    // the last element of a square matrix sits on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_matrix |-> o_out_row == o_out_col)
        else $error("last element off the diagonal");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind matrix_row_sort_by_abs_sum mrs_check u_check (.*);
